/* rtl/lssr_pkg.sv */
// shared types and constants for the load sample spike rejector
package lssr_pkg;

  localparam int SampleW  = 24;
  localparam int CountW   = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;

  localparam logic [CountW-1:0] HitsMax = '1;

  localparam logic [SampleW-1:0] MaxJumpRst = SampleW'(1000);
  localparam logic [CountW-1:0]  ConfirmRst = CountW'(3);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OK_SKIPS    = 3'd1,
    ST_NEW_LEVEL   = 3'd2,
    ST_ALL_SKIPPED = 3'd3,
    ST_TIMEOUT     = 3'd4
  } lssr_status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_JUMP      = 1'd0,
    REG_CONFIRM_COUNT = 1'd1
  } lssr_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] max_jump;
    logic [CountW-1:0]  confirm_count;
  } lssr_cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] raw_sample;
    logic                      read_timeout;
    logic                      last_in_batch;
  } lssr_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] weight_raw;
    logic                      valid_res;
    lssr_status_t              status;
  } lssr_res_t;

endpackage

/* rtl/lssr_filt.sv */
// filter state and per-item update of the spike rejector
module lssr_filt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  lssr_pkg::lssr_item_t item,
  input  lssr_pkg::lssr_cfg_t  cfg,
  output logic               res_vld,
  output lssr_pkg::lssr_res_t  res
);
  import lssr_pkg::*;

  logic signed [SampleW-1:0] good_r, good_nxt;
  logic                      good_known_r, good_known_nxt;
  logic signed [SampleW-1:0] cand_r, cand_nxt;
  logic                      cand_known_r, cand_known_nxt;
  logic [CountW-1:0]         hits_r, hits_nxt;
  logic signed [SampleW-1:0] blast_r, blast_nxt;
  logic                      bacc_r, bacc_nxt;
  logic                      bskip_r, bskip_nxt;
  logic                      bnew_r, bnew_nxt;

  logic signed [SampleW:0] d_good, d_cand;
  logic [SampleW:0]        m_good, m_cand;
  logic                    close_good, close_cand;
  logic [CountW-1:0]       hits_inc;

  // exact distances on one extra bit
  always_comb begin
    d_good = {item.raw_sample[SampleW-1], item.raw_sample} - {good_r[SampleW-1], good_r};
    d_cand = {item.raw_sample[SampleW-1], item.raw_sample} - {cand_r[SampleW-1], cand_r};
    m_good = d_good[SampleW] ? (SampleW+1)'(-d_good) : d_good;
    m_cand = d_cand[SampleW] ? (SampleW+1)'(-d_cand) : d_cand;
    close_good = m_good <= {1'b0, cfg.max_jump};
    close_cand = m_cand <= {1'b0, cfg.max_jump};
    hits_inc   = (hits_r == HitsMax) ? HitsMax : hits_r + CountW'(1);
  end

  always_comb begin
    good_nxt       = good_r;
    good_known_nxt = good_known_r;
    cand_nxt       = cand_r;
    cand_known_nxt = cand_known_r;
    hits_nxt       = hits_r;
    blast_nxt      = blast_r;
    bacc_nxt       = bacc_r;
    bskip_nxt      = bskip_r;
    bnew_nxt       = bnew_r;
    res            = '{weight_raw: '0, valid_res: 1'b0, status: ST_TIMEOUT};
    res_vld        = item.read_timeout | item.last_in_batch;

    if (item.read_timeout) begin
      blast_nxt = '0;
      bacc_nxt  = 1'b0;
      bskip_nxt = 1'b0;
      bnew_nxt  = 1'b0;
    end else begin
      if (!good_known_r || close_good) begin
        good_nxt       = item.raw_sample;
        good_known_nxt = 1'b1;
        blast_nxt      = item.raw_sample;
        bacc_nxt       = 1'b1;
        if (good_known_r) begin
          cand_known_nxt = 1'b0;
          hits_nxt       = '0;
        end
      end else if (!cand_known_r || !close_cand) begin
        // fresh candidate level
        cand_nxt       = item.raw_sample;
        cand_known_nxt = 1'b1;
        hits_nxt       = CountW'(1);
        bskip_nxt      = 1'b1;
      end else if (hits_inc >= cfg.confirm_count) begin
        // candidate confirmed as the new level
        good_nxt       = item.raw_sample;
        blast_nxt      = item.raw_sample;
        bacc_nxt       = 1'b1;
        cand_known_nxt = 1'b0;
        hits_nxt       = '0;
        bnew_nxt       = 1'b1;
      end else begin
        hits_nxt  = hits_inc;
        bskip_nxt = 1'b1;
      end

      if (!bacc_nxt)     res.status = ST_ALL_SKIPPED;
      else if (bnew_nxt) res.status = ST_NEW_LEVEL;
      else if (bskip_nxt) res.status = ST_OK_SKIPS;
      else               res.status = ST_OK;
      res.valid_res  = bacc_nxt;
      res.weight_raw = bacc_nxt ? blast_nxt : '0;

      if (item.last_in_batch) begin
        blast_nxt = '0;
        bacc_nxt  = 1'b0;
        bskip_nxt = 1'b0;
        bnew_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r       <= '0;
      good_known_r <= 1'b0;
      cand_r       <= '0;
      cand_known_r <= 1'b0;
      hits_r       <= '0;
      blast_r      <= '0;
      bacc_r       <= 1'b0;
      bskip_r      <= 1'b0;
      bnew_r       <= 1'b0;
    end else if (step) begin
      good_r       <= good_nxt;
      good_known_r <= good_known_nxt;
      cand_r       <= cand_nxt;
      cand_known_r <= cand_known_nxt;
      hits_r       <= hits_nxt;
      blast_r      <= blast_nxt;
      bacc_r       <= bacc_nxt;
      bskip_r      <= bskip_nxt;
      bnew_r       <= bnew_nxt;
    end
  end

endmodule

/* rtl/load_sample_spike_rejector.sv */
// top level of the load sample spike rejector
//
// Rejects single-sample spikes in a stream of signed 24-bit load cell samples.
// The first sample after reset sets the good level; a later sample is taken
// when it lies within max_jump of the good level, otherwise it is skipped and
// followed as a candidate level, which becomes the new good level once
// confirm_count close samples agree (a fresh candidate needs at least one more
// close sample). An item flagged as the last of its batch, or flagged as a read
// timeout, produces one result item with a status; for a batch end it carries
// the last value taken in the batch, for a timeout zero. All other items produce
// nothing. The block takes one item per clock while the output is not blocked:
// each item sits in an input register while the filter update runs, and a result
// lands in an output register, from which it is offered. Only an item that ends
// a batch or times out can wait on a full output register. The user must write
// configuration through cfg_we/cfg_idx/cfg_wdata only while no item is in
// flight; the block itself does not enforce it.
module load_sample_spike_rejector (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lssr_pkg::SampleW-1:0]  in_tdata,   // [23:0] raw_sample
  input  logic                          in_tuser,   // [0] read_timeout
  input  logic                          in_tlast,   // last_in_batch
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lssr_pkg::SampleW-1:0]  out_tdata,  // [23:0] weight_raw
  output logic [3:0]                    out_tuser,  // [0] valid_res, [3:1] status
  // configuration write port
  input  logic                          cfg_we,
  input  logic [lssr_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [lssr_pkg::CfgDataW-1:0] cfg_wdata
);
  import lssr_pkg::*;

  lssr_cfg_t  cfg_r;
  lssr_item_t s1_r;
  logic       s1_vld_r;
  lssr_res_t  out_r;
  logic       out_vld_r;

  logic       res_vld;
  lssr_res_t  res;
  logic       s1_adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_jump      <= MaxJumpRst;
      cfg_r.confirm_count <= ConfirmRst;
    end else if (cfg_we) begin
      case (lssr_reg_t'(cfg_idx))
        REG_MAX_JUMP:      cfg_r.max_jump      <= cfg_wdata;
        REG_CONFIRM_COUNT: cfg_r.confirm_count <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // the staged item moves on unless it has a result and the output is blocked
  assign s1_adv    = s1_vld_r && (!res_vld || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= '{raw_sample: in_tdata, read_timeout: in_tuser, last_in_batch: in_tlast};
    end
  end

  lssr_filt u_filt (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .item    (s1_r),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.weight_raw;
  assign out_tuser  = {out_r.status, out_r.valid_res};

  // a staged item that cannot move on stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_r))
    else $error("staged item lost or changed while held");

  // a timeout result never carries a value
  a_timeout_empty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_r.read_timeout |=> out_vld_r && out_r.status == ST_TIMEOUT
      && !out_r.valid_res && out_r.weight_raw == '0)
    else $error("timeout result malformed");

  // for a non-timeout result, all-skipped status goes with an empty result and vice versa
  a_skip_flag: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res_vld && !s1_r.read_timeout |=>
      (out_r.status == ST_ALL_SKIPPED) == !out_r.valid_res)
    else $error("all-skipped status and valid flag disagree");

endmodule

/* verif/lssr_checker.sv */
// result checker for the load sample spike rejector: mirrors the filter and compares result items
`timescale 1ns / 100ps
module lssr_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [lssr_pkg::SampleW-1:0]  in_tdata,   // [23:0] raw_sample
  input  logic                          in_tuser,   // [0] read_timeout
  input  logic                          in_tlast,   // last_in_batch
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [lssr_pkg::SampleW-1:0]  out_tdata,  // [23:0] weight_raw
  input  logic [3:0]                    out_tuser,  // [0] valid_res, [3:1] status
  input  logic                          cfg_we,
  input  logic [lssr_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [lssr_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            error_count,
  output int                            reports_pending
);
  import lssr_pkg::*;

  logic [SampleW-1:0]        max_jump;
  logic [CountW-1:0]         confirm_count;

  logic signed [SampleW-1:0] good_level;
  logic                      good_known;
  logic signed [SampleW-1:0] cand_level;
  logic                      cand_known;
  logic [CountW-1:0]         cand_hits;
  logic signed [SampleW-1:0] batch_value;
  logic                      batch_took;
  logic                      batch_skipped;
  logic                      batch_new_level;

  lssr_res_t expected_reports[$];

  // distance on one extra bit so nothing wraps
  function automatic logic is_close(input logic signed [SampleW-1:0] a,
                                    input logic signed [SampleW-1:0] b);
    logic [SampleW:0] diff;
    logic [SampleW:0] mag;
    diff = {a[SampleW-1], a} - {b[SampleW-1], b};
    mag  = diff[SampleW] ? -diff : diff;
    return mag <= {1'b0, max_jump};
  endfunction

  function automatic int field_diff(input string field, input logic signed [31:0] want,
                                    input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic take_value(input logic signed [SampleW-1:0] v);
    good_level  = v;
    good_known  = 1'b1;
    batch_value = v;
    batch_took  = 1'b1;
  endtask

  task automatic clear_batch();
    batch_value     = '0;
    batch_took      = 1'b0;
    batch_skipped   = 1'b0;
    batch_new_level = 1'b0;
  endtask

  task automatic predict_item(input logic signed [SampleW-1:0] raw, input logic timeout,
                              input logic last);
    lssr_res_t res;
    if (timeout) begin
      // sample and batch flag are ignored, filter state is kept
      clear_batch();
      res.weight_raw = '0;
      res.valid_res  = 1'b0;
      res.status     = ST_TIMEOUT;
      expected_reports.push_back(res);
    end else begin
      if (!good_known) begin
        take_value(raw);
      end else if (is_close(raw, good_level)) begin
        take_value(raw);
        cand_known = 1'b0;
        cand_hits  = '0;
      end else if (!cand_known || !is_close(raw, cand_level)) begin
        cand_level    = raw;
        cand_known    = 1'b1;
        cand_hits     = CountW'(1);
        batch_skipped = 1'b1;
      end else begin
        if (cand_hits != HitsMax) cand_hits = cand_hits + 1'b1;
        if (cand_hits >= confirm_count) begin
          take_value(raw);
          cand_known      = 1'b0;
          cand_hits       = '0;
          batch_new_level = 1'b1;
        end else begin
          batch_skipped = 1'b1;
        end
      end
      if (last) begin
        if (!batch_took) begin
          res.weight_raw = '0;
          res.valid_res  = 1'b0;
          res.status     = ST_ALL_SKIPPED;
        end else begin
          res.weight_raw = batch_value;
          res.valid_res  = 1'b1;
          res.status     = batch_new_level ? ST_NEW_LEVEL :
                           batch_skipped   ? ST_OK_SKIPS  : ST_OK;
        end
        expected_reports.push_back(res);
        clear_batch();
      end
    end
  endtask

  always @(posedge clk) begin
    lssr_res_t got;
    lssr_res_t want;
    if (!rst_n) begin
      max_jump      = MaxJumpRst;
      confirm_count = ConfirmRst;
      good_level    = '0;
      good_known    = 1'b0;
      cand_level    = '0;
      cand_known    = 1'b0;
      cand_hits     = '0;
      clear_batch();
      expected_reports.delete();
      error_count = 0;
    end else begin
      // older results leave first, then the new item is predicted
      if (out_tvalid && out_tready) begin
        got.weight_raw = out_tdata;
        got.valid_res  = out_tuser[0];
        got.status     = lssr_status_t'(out_tuser[3:1]);
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result item: weight_raw %0d valid_res %0b status %0d",
                   $time, got.weight_raw, got.valid_res, got.status);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          error_count += field_diff("weight_raw", want.weight_raw, got.weight_raw);
          error_count += field_diff("valid_res", {31'b0, want.valid_res},
                                    {31'b0, got.valid_res});
          error_count += field_diff("status", {29'b0, want.status}, {29'b0, got.status});
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tdata, in_tuser, in_tlast);
      if (cfg_we) begin
        case (lssr_reg_t'(cfg_idx))
          REG_MAX_JUMP:      max_jump = cfg_wdata;
          REG_CONFIRM_COUNT: confirm_count = cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
    end
    reports_pending <= expected_reports.size();
  end

endmodule

/* verif/tb_load_sample_spike_rejector.sv */
// testbench top for the load sample spike rejector: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_load_sample_spike_rejector;
  import lssr_pkg::*;

  localparam int RandomItems  = 1150;
  localparam int PhaseCount   = 10;
  localparam int CycleLimit   = 200000;
  localparam int LongHold     = 150;   // receiver hold-off, long enough to back up the input
  localparam int SettleCycles = 4;     // item pipeline depth plus margin
  localparam int SampleMax    = (1 << (SampleW - 1)) - 1;
  localparam int SampleMin    = -(1 << (SampleW - 1));
  localparam int JumpMax      = (1 << SampleW) - 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // every input starts at a known value
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SampleW-1:0]  in_tdata  = '0;   // [23:0] raw_sample
  logic                in_tuser  = 1'b0; // [0] read_timeout
  logic                in_tlast  = 1'b0; // last_in_batch
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SampleW-1:0]  out_tdata;        // [23:0] weight_raw
  logic [3:0]          out_tuser;        // [0] valid_res, [3:1] status
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int error_count;
  int reports_pending;

  // long hold-off requests from the sender side, served by the receiver
  int holds_wanted = 0;
  int holds_taken  = 0;

  always #5 clk = ~clk;

  load_sample_spike_rejector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  lssr_checker result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .reports_pending (reports_pending)
  );

  // watchdog on the whole run
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: picks a ready pattern per stretch; a requested or rare random
  // long hold-off keeps ready low until its hold counter runs out
  int unsigned ready_mode   = 0;
  int unsigned stretch_left = 0;
  int unsigned hold_left    = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stretch_left <= 0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_taken != holds_wanted) begin
      holds_taken <= holds_taken + 1;
      hold_left   <= LongHold;
      out_tready  <= 1'b0;
    end else begin
      // the hold-off mode is never kept: a new pattern is picked after its hold
      if (stretch_left == 0 || ready_mode > 10) begin
        ready_mode   <= $urandom_range(0, 11);
        stretch_left <= $urandom_range(8, 100);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (ready_mode)
        0, 1, 2, 8, 9, 10: out_tready <= 1'b1;             // no stalls at all
        3, 4:              out_tready <= 1'($urandom_range(0, 1));
        5, 6:              out_tready <= ($urandom_range(0, 3) == 0);
        7:                 out_tready <= ~out_tready;      // alternates high and low
        default: begin
          // occasional unrequested long hold-off
          out_tready <= 1'b0;
          hold_left  <= LongHold;
        end
      endcase
    end
  end

  // offer one item and return at the edge that accepts it
  task automatic send_item(input int sample, input bit timeout, input bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= sample[SampleW-1:0];
    in_tuser  <= timeout;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // sender goes quiet until every expected result has come back, then lets
  // samples that cause no result drain out of the pipeline
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // both registers are written back to back, only while the block is idle
  task automatic set_cfg(input int unsigned jump, input int unsigned confirm);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MAX_JUMP;
    cfg_wdata <= jump[CfgDataW-1:0];
    @(posedge clk);
    cfg_idx   <= REG_CONFIRM_COUNT;
    cfg_wdata <= {{(CfgDataW - CountW){1'b0}}, confirm[CountW-1:0]};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int any_reading();
    return int'($urandom_range(0, JumpMax)) + SampleMin;
  endfunction

  initial begin : stimulus
    int unsigned jump;
    int unsigned confirm;
    int level;
    int offset;
    int sample;
    int pick;
    int batch_len;
    int batch_pos;
    int burst_left;
    int sent;
    bit timeout;
    bit last;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset config: jump 1000, confirm 3
    send_item(SampleMin, 0, 1);          // very first sample is plain ok
    send_item(SampleMin + 608, 0, 0);    // close, accepted
    send_item(SampleMax, 0, 0);          // spike starts a candidate
    send_item(SampleMax, 0, 0);          // second hit, still skipped
    send_item(SampleMax - 607, 0, 1);    // third hit confirms the new level
    send_item(0, 0, 1);                  // only a skip in this batch
    send_item(0, 1, 1);                  // timeout with batch flag set
    send_item(500, 0, 0);                // hit on the candidate left from before
    send_item(SampleMin, 1, 0);          // timeout in mid batch
    send_item(SampleMax - 1607, 0, 0);   // exactly max_jump away: accepted
    send_item(SampleMax - 2608, 0, 1);   // one past max_jump: ok with skips
    send_item(SampleMax - 1607, 0, 1);   // plain ok

    // smallest jump and count: second close anomalous sample confirms
    set_cfg(0, 1);
    send_item(SampleMax - 1607, 0, 0);
    send_item(SampleMax - 1606, 0, 0);
    send_item(SampleMax - 1606, 0, 1);

    // widest jump: full-scale swings are still the same level
    set_cfg(JumpMax, 255);
    send_item(SampleMin, 0, 1);
    send_item(SampleMax, 0, 1);

    set_cfg(100, 2);
    send_item(-100000, 0, 1);            // all skipped
    send_item(-99900, 0, 1);             // confirmed after two hits

    // random part: phases with their own settings, each starting from idle
    sent       = 0;
    burst_left = 0;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin jump = 1000;    confirm = 3;   end
        1: begin jump = 0;       confirm = 1;   end
        2: begin jump = JumpMax; confirm = 255; end
        3: begin jump = 1;       confirm = 2;   end
        4: begin jump = $urandom_range(0, JumpMax); confirm = $urandom_range(1, 255); end
        default: begin
          pick    = $urandom_range(0, 3);
          jump    = (pick == 0) ? $urandom_range(0, 20) :
                    (pick == 1) ? $urandom_range(100, 5000) :
                    (pick == 2) ? $urandom_range(0, JumpMax) : 1000;
          confirm = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 6);
        end
      endcase
      set_cfg(jump, confirm);
      level     = any_reading();
      batch_len = $urandom_range(1, 12);
      batch_pos = 0;

      for (int n = 0; n < RandomItems / PhaseCount; n++) begin
        // ask the receiver for a long hold-off while items keep coming
        if ((phase == 2 || phase == 6) && n == 20) holds_wanted <= holds_wanted + 1;

        // mostly readings around a level that now and then steps away
        pick   = $urandom_range(0, 99);
        offset = int'($urandom_range(0, 2 * jump)) - int'(jump);
        if (pick < 60) begin
          sample = level + offset;
        end else if (pick < 68) begin
          sample = ($urandom_range(0, 1) != 0) ? level + int'(jump) + 1 : level - int'(jump) - 1;
        end else if (pick < 78) begin
          sample = any_reading();        // lone spike
        end else if (pick < 88) begin
          level  = any_reading();        // lasting step to a new level
          sample = level + offset;
        end else begin
          sample = ($urandom_range(0, 1) != 0) ? level + int'(jump) : level - int'(jump);
        end
        if (sample > SampleMax) sample = SampleMax;
        if (sample < SampleMin) sample = SampleMin;

        timeout = ($urandom_range(0, 24) == 0);
        batch_pos++;
        last = (batch_pos >= batch_len);
        if (timeout) begin
          sample = any_reading();
          last   = 1'($urandom_range(0, 1));
          batch_pos = 0;
          batch_len = $urandom_range(1, 12);
        end else if (last) begin
          batch_pos = 0;
          batch_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
        end
        send_item(sample, timeout, last);
        sent++;

        // bursts of random length, sometimes long, with random gaps between
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) :
                                                     $urandom_range(1, 25);
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end else begin
          burst_left--;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lssr_pkg.sv
rtl/lssr_filt.sv
rtl/load_sample_spike_rejector.sv
verif/lssr_checker.sv
verif/tb_load_sample_spike_rejector.sv
